// File: hw/rtl/ilid_pkg.sv
// Shared types, codes and constants of the indexed list block.
package ilid_pkg;

  // Default number of entries in the list store.
  localparam int unsigned CAPACITY = 128;

  // Field widths fixed by the item formats.
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CNT_W  = 8;

  // Command codes; the fourth code is unused and is reported as out of range.
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_BUSY = 2'b10
  } state_e;

endpackage

// File: hw/rtl/ilid_cmd_if.sv
// Command channel: valid/ready handshake carrying one list command.
interface ilid_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [ilid_pkg::CMD_W-1:0]        command;
  logic [ilid_pkg::POS_W-1:0]        position;
  logic signed [ilid_pkg::DATA_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

// File: hw/rtl/ilid_rsp_if.sv
// Response channel: valid/ready handshake carrying one command result.
interface ilid_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [ilid_pkg::STAT_W-1:0]       status;
  logic signed [ilid_pkg::DATA_W-1:0] data_out;
  logic [ilid_pkg::CNT_W-1:0]        count;

  modport source (output valid, status, data_out, count, input ready);
  modport sink   (input valid, status, data_out, count, output ready);
endinterface

// File: hw/rtl/indexed_list_insert_delete.sv
// Top level of the indexed list: command sequencer around the list store RAM.
//
//   Channel  Direction  Fields                       Transfer when
//   cmd_i    in         command, position, value     cmd_i.valid && cmd_i.ready
//   rsp_o    out        status, data_out, count      rsp_o.valid && rsp_o.ready
//
// A command is taken while the sequencer is idle and then sweeps the RAM,
// one read a cycle, with each moved word written back one place up (insert)
// or down (delete) in the cycle after its read. Insert moves the words from
// the given position to the end; delete returns the word at the position and
// moves those after it; read fetches one word. An append at the end or a
// rejected command does no sweep.
// Reset clears the length and the handshake state; the RAM itself is not
// cleared. A result waits in an output register; a stalled response only
// holds the sequencer in its final cycle.
module indexed_list_insert_delete #(
  parameter int unsigned CAPACITY = ilid_pkg::CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ilid_cmd_if.sink   cmd_i,
  ilid_rsp_if.source rsp_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > ilid_pkg::POS_W) ? LW : ilid_pkg::POS_W) + 1;
  localparam int unsigned DW = ilid_pkg::DATA_W;

  ilid_pkg::state_e  state_q, state_d;
  logic              issue_q, issue_d;
  logic              rd_vld_q, rd_vld_d;
  logic              cap_q, cap_d;
  logic              ins_q, ins_d;
  logic              del_q, del_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     last_q, last_d;
  logic [AW-1:0]     rd_addr_q, rd_addr_d;
  logic [AW-1:0]     pos0_q, pos0_d;
  logic [DW-1:0]     val_q, val_d;
  logic [DW-1:0]     data_q, data_d;
  ilid_pkg::status_e st_q, st_d;
  logic [LW-1:0]     len_q, len_d;

  logic                          out_vld_q, out_vld_d;
  logic [ilid_pkg::STAT_W-1:0]   out_st_q, out_st_d;
  logic [DW-1:0]                 out_data_q, out_data_d;
  logic [ilid_pkg::CNT_W-1:0]    out_cnt_q, out_cnt_d;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata, ram_rdata;

  logic [CW-1:0] pos_ext, len_ext, len_ext_d;
  logic          pos_ok_ins, pos_ok_acc, full;

  ilid_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Range checks on the incoming position.
  assign pos_ext    = CW'(cmd_i.position);
  assign len_ext    = CW'(len_q);
  assign pos_ok_ins = (pos_ext != '0) && (pos_ext <= len_ext + 1'b1);
  assign pos_ok_acc = (pos_ext != '0) && (pos_ext <= len_ext);
  assign full       = (len_q >= LW'(CAPACITY));
  assign len_ext_d  = CW'(len_d);

  assign cmd_i.ready = (state_q == ilid_pkg::S_IDLE);

  // Sequencer: take a command, sweep the store, then load the result.
  always_comb begin
    state_d    = state_q;
    issue_d    = issue_q;
    rd_vld_d   = 1'b0;
    cap_d      = cap_q;
    ins_d      = ins_q;
    del_d      = del_q;
    ptr_d      = ptr_q;
    last_d     = last_q;
    rd_addr_d  = rd_addr_q;
    pos0_d     = pos0_q;
    val_d      = val_q;
    data_d     = data_q;
    st_d       = st_q;
    len_d      = len_q;
    out_vld_d  = out_vld_q && !rsp_o.ready;
    out_st_d   = out_st_q;
    out_data_d = out_data_q;
    out_cnt_d  = out_cnt_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = rd_addr_q;
    ram_wdata  = ram_rdata;

    unique case (state_q)
      ilid_pkg::S_IDLE: begin
        if (cmd_i.valid) begin
          val_d   = cmd_i.value;
          data_d  = '0;
          cap_d   = 1'b0;
          issue_d = 1'b0;
          ins_d   = 1'b0;
          del_d   = 1'b0;
          st_d    = ilid_pkg::ST_RANGE;
          pos0_d  = AW'(pos_ext - 1'b1);
          unique case (ilid_pkg::cmd_e'(cmd_i.command))
            ilid_pkg::CMD_INSERT: begin
              if (pos_ok_ins) begin
                if (full) begin
                  st_d = ilid_pkg::ST_FULL;
                end else begin
                  st_d  = ilid_pkg::ST_DONE;
                  ins_d = 1'b1;
                  // Appending at the end needs no shift.
                  if (pos_ext != len_ext + 1'b1) begin
                    issue_d = 1'b1;
                    ptr_d   = AW'(len_ext - 1'b1);
                    last_d  = AW'(pos_ext - 1'b1);
                  end
                end
              end
            end
            ilid_pkg::CMD_DELETE: begin
              if (pos_ok_acc) begin
                st_d    = ilid_pkg::ST_DONE;
                del_d   = 1'b1;
                cap_d   = 1'b1;
                issue_d = 1'b1;
                ptr_d   = AW'(pos_ext - 1'b1);
                last_d  = AW'(len_ext - 1'b1);
              end
            end
            ilid_pkg::CMD_READ: begin
              if (pos_ok_acc) begin
                st_d    = ilid_pkg::ST_DONE;
                cap_d   = 1'b1;
                issue_d = 1'b1;
                ptr_d   = AW'(pos_ext - 1'b1);
                last_d  = AW'(pos_ext - 1'b1);
              end
            end
            default: begin
            end
          endcase
          state_d = ilid_pkg::S_BUSY;
        end
      end
      ilid_pkg::S_BUSY: begin
        // Issue the next read of the sweep.
        ram_re    = issue_q;
        rd_vld_d  = issue_q;
        rd_addr_d = ptr_q;
        if (issue_q) begin
          if (ptr_q == last_q) begin
            issue_d = 1'b0;
          end else if (ins_q) begin
            ptr_d = ptr_q - 1'b1;
          end else begin
            ptr_d = ptr_q + 1'b1;
          end
        end
        // Returning word: capture it or write it one place over.
        if (rd_vld_q) begin
          if (cap_q) begin
            data_d = ram_rdata;
            cap_d  = 1'b0;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = ins_q ? (rd_addr_q + 1'b1) : (rd_addr_q - 1'b1);
          end
        end else if (!issue_q && (!out_vld_q || rsp_o.ready)) begin
          // Sweep drained: place the new word, update the length, post the result.
          if (ins_q) begin
            ram_we    = 1'b1;
            ram_waddr = pos0_q;
            ram_wdata = val_q;
            len_d     = len_q + 1'b1;
          end
          if (del_q) begin
            len_d = len_q - 1'b1;
          end
          out_vld_d  = 1'b1;
          out_st_d   = st_q;
          out_data_d = data_q;
          out_cnt_d  = len_ext_d[ilid_pkg::CNT_W-1:0];
          state_d    = ilid_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ilid_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ilid_pkg::S_IDLE;
      issue_q   <= 1'b0;
      rd_vld_q  <= 1'b0;
      cap_q     <= 1'b0;
      ins_q     <= 1'b0;
      del_q     <= 1'b0;
      len_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      rd_vld_q  <= rd_vld_d;
      cap_q     <= cap_d;
      ins_q     <= ins_d;
      del_q     <= del_d;
      len_q     <= len_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ptr_q      <= ptr_d;
    last_q     <= last_d;
    rd_addr_q  <= rd_addr_d;
    pos0_q     <= pos0_d;
    val_q      <= val_d;
    data_q     <= data_d;
    st_q       <= st_d;
    out_st_q   <= out_st_d;
    out_data_q <= out_data_d;
    out_cnt_q  <= out_cnt_d;
  end

  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.status   = out_st_q;
  assign rsp_o.data_out = out_data_q;
  assign rsp_o.count    = out_cnt_q;

  // The length never exceeds the store.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LW'(CAPACITY))
    else $error("list length beyond capacity");

  // The store is only written while a command is in progress.
  a_no_idle_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ilid_pkg::S_IDLE) |-> !ram_we)
    else $error("store written while idle");

  // Every write lands inside the store.
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr < AW'(CAPACITY - 1) || ram_waddr == AW'(CAPACITY - 1)))
    else $error("store write outside capacity");

  // A pending result reports the current length.
  a_count_tracks_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_cnt_q == len_ext[ilid_pkg::CNT_W-1:0]))
    else $error("result count differs from list length");

  // A word returning from the RAM never coincides with the final write.
  a_read_before_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_vld_q && state_q == ilid_pkg::S_BUSY) |=> (state_q == ilid_pkg::S_BUSY))
    else $error("command finished with a read still in flight");

endmodule

// File: hw/rtl/ilid_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ilid_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
